@@ rtl/core/bmm_pkg.sv @@
package bmm_pkg;

   // default fraction widths
   localparam int ANGLE_FRAC_BITS_DEF = 13;
   localparam int OUT_FRAC_BITS_DEF   = 16;

   // trig lanes per pose and rotation count
   localparam int LANES        = 11;
   localparam int CORDIC_STEPS = 24;
   localparam int XY_W         = 34;
   localparam int COEF_W       = 33;
   localparam int SUM_W        = 48;
   localparam int ROWS         = 7;
   localparam logic [2:0] LAST_ROW = 3'd6;

   // angle constants in q.24 radians, trig in q.30
   localparam logic signed [31:0] PI_Q24      = 32'sd52707179;
   localparam logic signed [31:0] TWO_PI_Q24  = 32'sd105414358;
   localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [XY_W-1:0] TRIG_ONE    = 34'sd1073741824;
   localparam logic [63:0] COEF_MAX = 64'h1_FFFF_FFFF;

   // register indexes
   typedef enum logic [2:0] {
      CSR_THIGH_LENGTH       = 3'd0,
      CSR_LEG_LENGTH         = 3'd1,
      CSR_PELVIS_HIP_OFFSET  = 3'd2,
      CSR_THIGH_MASS         = 3'd3,
      CSR_THIGH_INERTIA      = 3'd4,
      CSR_LEG_MASS           = 3'd5,
      CSR_LEG_INERTIA        = 3'd6,
      CSR_TORSO_MASS_INERTIA = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] right_hip_angle;
      logic signed [15:0] right_knee_angle;
      logic signed [15:0] left_hip_angle;
      logic signed [15:0] left_knee_angle;
      logic signed [15:0] torso_pitch;
   } req_type;

   typedef struct packed {
      logic [2:0]         row_number;
      logic signed [31:0] elem_col0;
      logic signed [31:0] elem_col1;
      logic signed [31:0] elem_col2;
      logic signed [31:0] elem_col3;
      logic signed [31:0] elem_col4;
      logic signed [31:0] elem_col5;
      logic signed [31:0] elem_col6;
      logic               last_row;
   } rsp_type;

   typedef struct packed {
      logic [23:0] thigh_length;
      logic [23:0] leg_length;
      logic [23:0] pelvis_hip_offset;
      logic [23:0] thigh_mass;
      logic [23:0] thigh_inertia;
      logic [23:0] leg_mass;
      logic [23:0] leg_inertia;
      logic [47:0] torso_mass_inertia;
   } cfg_type;

   // mass-length coefficients, unsigned q.16
   typedef struct packed {
      logic [COEF_W-1:0] klc;
      logic [COEF_W-1:0] kb;
      logic [COEF_W-1:0] ka;
      logic [COEF_W-1:0] kc;
      logic [COEF_W-1:0] kt1;
      logic [COEF_W-1:0] kpl;
      logic [COEF_W-1:0] kpt;
      logic [COEF_W-1:0] km;
      logic [COEF_W-1:0] kp7;
      logic [COEF_W-1:0] kd;
   } coef_type;

   function automatic logic signed [31:0] atan_q24(input int i);
      logic signed [31:0] r;
      case (i)
         0:  r = 32'sd13176795;
         1:  r = 32'sd7778716;
         2:  r = 32'sd4110060;
         3:  r = 32'sd2086331;
         4:  r = 32'sd1047214;
         5:  r = 32'sd524117;
         6:  r = 32'sd262123;
         7:  r = 32'sd131069;
         default: r = 32'sd65536 >>> (i - 8);
      endcase
      return r;
   endfunction

   function automatic logic [COEF_W-1:0] csat(input logic [63:0] v);
      return (v > COEF_MAX) ? COEF_MAX[COEF_W-1:0] : v[COEF_W-1:0];
   endfunction

   // product rounded half up, then saturated
   function automatic logic [COEF_W-1:0] qmul(input logic [COEF_W-1:0] a,
                                              input logic [25:0] b,
                                              input logic [4:0] sh);
      logic [63:0] p;
      p = {31'd0, a} * {38'd0, b};
      p = (p + (64'd1 << (sh - 5'd1))) >> sh;
      return csat(p);
   endfunction

   function automatic logic [COEF_W-1:0] cadd(input logic [63:0] a, input logic [63:0] b);
      return csat({31'd0, csat(a)} + {31'd0, csat(b)});
   endfunction

endpackage

@@ rtl/core/bmm_coef.sv @@
module bmm_coef (
   input  logic               clock,
   input  bmm_pkg::cfg_type   cfg,
   output bmm_pkg::coef_type  coef
);

   localparam int CW = bmm_pkg::COEF_W;

   logic [CW-1:0] klc1_ff, lt2_1_ff, mtlt1_ff, mllt1_ff, pp1_ff, km1_ff;
   logic [24:0]   mlmt1_ff;
   logic [CW-1:0] kb2_ff, klcll2_ff, t1_2_ff, t2_2_ff, kt1_2_ff, kpl2_ff, kp7_2_ff, ppm2_ff;
   logic [CW-1:0] kc3_ff, ts3_ff, kpt3_ff, ka4_ff, kd5_ff;
   logic [23:0]   lt, ll, p, mt, it, ml, il, mp, ip;

   assign lt = cfg.thigh_length;
   assign ll = cfg.leg_length;
   assign p  = cfg.pelvis_hip_offset;
   assign mt = cfg.thigh_mass;
   assign it = cfg.thigh_inertia;
   assign ml = cfg.leg_mass;
   assign il = cfg.leg_inertia;
   assign mp = cfg.torso_mass_inertia[47:24];
   assign ip = cfg.torso_mass_inertia[23:0];

   // free-running chain with no enable or reset, fed straight from the link registers
   always_ff @(posedge clock) begin
      // first products
      klc1_ff  <= bmm_pkg::qmul(CW'(ml), 26'(ll), 5'd17);
      lt2_1_ff <= bmm_pkg::qmul(CW'(lt), 26'(lt), 5'd16);
      mtlt1_ff <= bmm_pkg::qmul(CW'(mt), 26'(lt), 5'd17);
      mllt1_ff <= bmm_pkg::qmul(CW'(ml), 26'(lt), 5'd16);
      pp1_ff   <= bmm_pkg::qmul(CW'(p), 26'(p), 5'd16);
      mlmt1_ff <= {1'b0, ml} + {1'b0, mt};
      km1_ff   <= bmm_pkg::cadd(bmm_pkg::cadd({39'd0, ml, 1'b0}, 64'(mp)),
                                {39'd0, mt, 1'b0});
      // second products
      kb2_ff    <= bmm_pkg::qmul(klc1_ff, 26'(lt), 5'd16);
      klcll2_ff <= bmm_pkg::qmul(klc1_ff, 26'(ll), 5'd17);
      t1_2_ff   <= bmm_pkg::qmul(lt2_1_ff, 26'(ml), 5'd16);
      t2_2_ff   <= bmm_pkg::qmul(mtlt1_ff, 26'(lt), 5'd17);
      kt1_2_ff  <= bmm_pkg::cadd(64'(mllt1_ff), 64'(mtlt1_ff));
      kpl2_ff   <= bmm_pkg::qmul(klc1_ff, 26'(p), 5'd16);
      kp7_2_ff  <= bmm_pkg::qmul(CW'(mlmt1_ff), 26'(p), 5'd16);
      ppm2_ff   <= bmm_pkg::qmul(pp1_ff, 26'(mlmt1_ff), 5'd16);
      // third level
      kc3_ff  <= bmm_pkg::cadd(64'(il), 64'(klcll2_ff));
      ts3_ff  <= bmm_pkg::cadd(64'(t1_2_ff), 64'(t2_2_ff));
      kpt3_ff <= bmm_pkg::qmul(kt1_2_ff, 26'(p), 5'd16);
      // thigh-leg diagonal term
      ka4_ff <= bmm_pkg::cadd(bmm_pkg::cadd(64'(kc3_ff), 64'(it)), 64'(ts3_ff));
      // torso pitch diagonal term
      kd5_ff <= bmm_pkg::cadd(bmm_pkg::cadd({30'd0, ka4_ff, 1'b0}, 64'(ip)),
                              {30'd0, ppm2_ff, 1'b0});
   end

   assign coef.klc = klc1_ff;
   assign coef.kb  = kb2_ff;
   assign coef.ka  = ka4_ff;
   assign coef.kc  = kc3_ff;
   assign coef.kt1 = kt1_2_ff;
   assign coef.kpl = kpl2_ff;
   assign coef.kpt = kpt3_ff;
   assign coef.km  = km1_ff;
   assign coef.kp7 = kp7_2_ff;
   assign coef.kd  = kd5_ff;

endmodule

@@ rtl/core/bmm_trig.sv @@
module bmm_trig #(
   parameter int ANGLE_FRAC_BITS = bmm_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               en,
   input  bmm_pkg::req_type   angles,
   output logic signed [31:0] cos_out [bmm_pkg::LANES],
   output logic signed [31:0] sin_out [bmm_pkg::LANES]
);

   localparam int NL = bmm_pkg::LANES;
   localparam int NS = bmm_pkg::CORDIC_STEPS;
   localparam int XW = bmm_pkg::XY_W;
   localparam int SH = 24 - ANGLE_FRAC_BITS;

   logic signed [31:0] q1, q2, q3, q4, q7;
   logic signed [31:0] sum_c [NL];
   logic signed [31:0] a_ff [NL];
   logic [31:0]        rem_ff [4][NL];
   logic               neg_ff [4][NL];
   logic signed [31:0] z5_ff [NL];
   logic signed [31:0] z6_ff [NL];
   logic signed [XW-1:0] x_ff [NS+1][NL];
   logic signed [XW-1:0] y_ff [NS+1][NL];
   logic signed [31:0]   zc_ff [NS+1][NL];
   logic                 flip_ff [NS+1][NL];
   logic signed [XW-1:0] cx_c [NL];
   logic signed [XW-1:0] sy_c [NL];
   logic signed [31:0]   cos_ff [NL];
   logic signed [31:0]   sin_ff [NL];

   // angles to q.24
   assign q1 = 32'(angles.right_hip_angle) <<< SH;
   assign q2 = 32'(angles.right_knee_angle) <<< SH;
   assign q3 = 32'(angles.left_hip_angle) <<< SH;
   assign q4 = 32'(angles.left_knee_angle) <<< SH;
   assign q7 = 32'(angles.torso_pitch) <<< SH;

   // lane angle sums
   assign sum_c[0]  = q1;
   assign sum_c[1]  = q2;
   assign sum_c[2]  = q3;
   assign sum_c[3]  = q4;
   assign sum_c[4]  = q1 + q2;
   assign sum_c[5]  = q3 + q4;
   assign sum_c[6]  = q7 + q1;
   assign sum_c[7]  = q7 + q3;
   assign sum_c[8]  = q7 + q1 + q2;
   assign sum_c[9]  = q7 + q3 + q4;
   assign sum_c[10] = q7;

   // range reduction and rotation stages
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < NL; l++) begin
            a_ff[l] <= sum_c[l];
            // magnitude and sign
            neg_ff[0][l] <= a_ff[l][31];
            rem_ff[0][l] <= a_ff[l][31] ? 32'(-a_ff[l]) : 32'(a_ff[l]);
            // remainder by two pi, one restoring step per stage
            for (int s = 1; s < 4; s++) begin
               neg_ff[s][l] <= neg_ff[s-1][l];
               if (rem_ff[s-1][l] >= (32'(TWO_PI_Q24_U) << (3 - s)))
                  rem_ff[s][l] <= rem_ff[s-1][l] - (32'(TWO_PI_Q24_U) << (3 - s));
               else
                  rem_ff[s][l] <= rem_ff[s-1][l];
            end
            // restore sign
            z5_ff[l] <= neg_ff[3][l] ? -$signed(rem_ff[3][l]) : $signed(rem_ff[3][l]);
            // fold into minus pi to pi
            if (z5_ff[l] > bmm_pkg::PI_Q24)
               z6_ff[l] <= z5_ff[l] - bmm_pkg::TWO_PI_Q24;
            else if (z5_ff[l] < -bmm_pkg::PI_Q24)
               z6_ff[l] <= z5_ff[l] + bmm_pkg::TWO_PI_Q24;
            else
               z6_ff[l] <= z5_ff[l];
            // fold into the right half plane
            x_ff[0][l] <= bmm_pkg::CORDIC_GAIN;
            y_ff[0][l] <= '0;
            if (z6_ff[l] > bmm_pkg::HALF_PI_Q24) begin
               zc_ff[0][l]   <= z6_ff[l] - bmm_pkg::PI_Q24;
               flip_ff[0][l] <= 1'b1;
            end else if (z6_ff[l] < -bmm_pkg::HALF_PI_Q24) begin
               zc_ff[0][l]   <= z6_ff[l] + bmm_pkg::PI_Q24;
               flip_ff[0][l] <= 1'b1;
            end else begin
               zc_ff[0][l]   <= z6_ff[l];
               flip_ff[0][l] <= 1'b0;
            end
            // one rotation per stage
            for (int i = 0; i < NS; i++) begin
               flip_ff[i+1][l] <= flip_ff[i][l];
               if (zc_ff[i][l] >= 0) begin
                  x_ff[i+1][l]  <= x_ff[i][l] - (y_ff[i][l] >>> i);
                  y_ff[i+1][l]  <= y_ff[i][l] + (x_ff[i][l] >>> i);
                  zc_ff[i+1][l] <= zc_ff[i][l] - bmm_pkg::atan_q24(i);
               end else begin
                  x_ff[i+1][l]  <= x_ff[i][l] + (y_ff[i][l] >>> i);
                  y_ff[i+1][l]  <= y_ff[i][l] - (x_ff[i][l] >>> i);
                  zc_ff[i+1][l] <= zc_ff[i][l] + bmm_pkg::atan_q24(i);
               end
            end
            cos_ff[l] <= 32'(cx_c[l]);
            sin_ff[l] <= 32'(sy_c[l]);
         end
      end
   end

   localparam logic [31:0] TWO_PI_Q24_U = 32'(bmm_pkg::TWO_PI_Q24);

   // undo the fold and clamp to unit magnitude
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         cx_c[l] = flip_ff[NS][l] ? -x_ff[NS][l] : x_ff[NS][l];
         sy_c[l] = flip_ff[NS][l] ? -y_ff[NS][l] : y_ff[NS][l];
         if (cx_c[l] > bmm_pkg::TRIG_ONE) cx_c[l] = bmm_pkg::TRIG_ONE;
         if (cx_c[l] < -bmm_pkg::TRIG_ONE) cx_c[l] = -bmm_pkg::TRIG_ONE;
         if (sy_c[l] > bmm_pkg::TRIG_ONE) sy_c[l] = bmm_pkg::TRIG_ONE;
         if (sy_c[l] < -bmm_pkg::TRIG_ONE) sy_c[l] = -bmm_pkg::TRIG_ONE;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

@@ rtl/core/biped_mass_matrix.sv @@
// requests pass the pose pipeline into the seven-row serializer, which shows one row
// per cycle while rsp_ready is high and loads the next pose as its last row is taken
// the pose pipeline is 37 register stages (range reduction, 24 cordic rotations,
// multiply, round, two adder levels) and stalls as a whole when the serializer is full
// reset clears all valid bits and the serializer and loads the default link registers
module biped_mass_matrix #(
   parameter int ANGLE_FRAC_BITS = bmm_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS   = bmm_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bmm_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bmm_pkg::rsp_type  rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [47:0]       csr_data
);

   localparam int NL  = bmm_pkg::LANES;
   localparam int SW  = bmm_pkg::SUM_W;
   localparam int CW  = bmm_pkg::COEF_W;
   localparam int LAT = 37;
   localparam int NP  = 16;
   localparam int NE  = 23;
   localparam int UP  = (OUT_FRAC_BITS >= 16) ? (OUT_FRAC_BITS - 16) : 0;
   localparam int DN  = (OUT_FRAC_BITS < 16) ? (16 - OUT_FRAC_BITS) : 0;
   localparam logic signed [SW-1:0] RND = (DN > 0) ? (SW'(1) <<< (DN - 1)) : '0;
   localparam logic signed [SW-1:0] OUT_MAX = SW'(64'sd2147483647);
   localparam logic signed [SW-1:0] OUT_MIN = SW'(-64'sd2147483648);

   // product names
   localparam int PB2 = 0, PB4 = 1, PT71C = 2, PT71S = 3, PL712C = 4, PL712S = 5;
   localparam int PT73C = 6, PT73S = 7, PL734C = 8, PL734S = 9, PPL12 = 10, PPL34 = 11;
   localparam int PPT1 = 12, PPT3 = 13, PP7C = 14, PP7S = 15;
   // distinct matrix entries
   localparam int E00 = 0, E01 = 1, E04 = 2, E05 = 3, E06 = 4, E11 = 5, E14 = 6, E15 = 7;
   localparam int E16 = 8, E22 = 9, E23 = 10, E24 = 11, E25 = 12, E26 = 13, E33 = 14;
   localparam int E34 = 15, E35 = 16, E36 = 17, E44 = 18, E46 = 19, E55 = 20, E56 = 21;
   localparam int E66 = 22;

   bmm_pkg::cfg_type  cfg_ff;
   bmm_pkg::coef_type coef;
   logic              adv, drain, can_load, load;
   logic              vld_ff [LAT];
   logic              busy_ff;
   logic [2:0]        row_ff;
   logic signed [31:0] cos_w [NL];
   logic signed [31:0] sin_w [NL];
   logic [CW-1:0]     pcoef_c [NP];
   logic signed [31:0] ptrig_c [NP];
   logic [63:0]       mag_ff [NP];
   logic              psign_ff [NP];
   logic signed [SW-1:0] p_ff [NP];
   logic signed [SW-1:0] ha_c [NE];
   logic signed [SW-1:0] hb_c [NE];
   logic signed [SW-1:0] ha_ff [NE];
   logic signed [SW-1:0] hb_ff [NE];
   logic signed [SW-1:0] e_ff [NE];
   logic signed [SW-1:0] ka_s, kc_s, km_s, kd_s;
   logic signed [SW-1:0] sh_c [NE];
   logic signed [31:0]   eo_c [NE];
   logic signed [31:0]   full_c [bmm_pkg::ROWS][bmm_pkg::ROWS];
   logic signed [31:0]   mat_ff [bmm_pkg::ROWS][bmm_pkg::ROWS];

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thigh_length       <= 24'd12452;
         cfg_ff.leg_length         <= 24'd15401;
         cfg_ff.pelvis_hip_offset  <= 24'd13763;
         cfg_ff.thigh_mass         <= 24'd45875;
         cfg_ff.thigh_inertia      <= 24'd293;
         cfg_ff.leg_mass           <= 24'd45875;
         cfg_ff.leg_inertia        <= 24'd293;
         cfg_ff.torso_mass_inertia <= 48'd13743895386548;
      end else if (csr_valid) begin
         unique case (bmm_pkg::csr_index_type'(csr_index))
            bmm_pkg::CSR_THIGH_LENGTH:       cfg_ff.thigh_length      <= csr_data[23:0];
            bmm_pkg::CSR_LEG_LENGTH:         cfg_ff.leg_length        <= csr_data[23:0];
            bmm_pkg::CSR_PELVIS_HIP_OFFSET:  cfg_ff.pelvis_hip_offset <= csr_data[23:0];
            bmm_pkg::CSR_THIGH_MASS:         cfg_ff.thigh_mass        <= csr_data[23:0];
            bmm_pkg::CSR_THIGH_INERTIA:      cfg_ff.thigh_inertia     <= csr_data[23:0];
            bmm_pkg::CSR_LEG_MASS:           cfg_ff.leg_mass          <= csr_data[23:0];
            bmm_pkg::CSR_LEG_INERTIA:        cfg_ff.leg_inertia       <= csr_data[23:0];
            bmm_pkg::CSR_TORSO_MASS_INERTIA: cfg_ff.torso_mass_inertia <= csr_data;
         endcase
      end
   end

   bmm_coef u_coef (
      .clock (clock),
      .cfg   (cfg_ff),
      .coef  (coef)
   );

   // pipeline flow control
   assign drain    = busy_ff && rsp_ready && (row_ff == bmm_pkg::LAST_ROW);
   assign can_load = !busy_ff || drain;
   assign adv      = !vld_ff[LAT-1] || can_load;
   assign load     = vld_ff[LAT-1] && can_load;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) vld_ff[s] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int s = 1; s < LAT; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   bmm_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_trig (
      .clock   (clock),
      .en      (adv),
      .angles  (req_payload),
      .cos_out (cos_w),
      .sin_out (sin_w)
   );

   // product operand selection
   always_comb begin
      pcoef_c[PB2] = coef.kb;   ptrig_c[PB2] = cos_w[1];
      pcoef_c[PB4] = coef.kb;   ptrig_c[PB4] = cos_w[3];
      pcoef_c[PT71C] = coef.kt1; ptrig_c[PT71C] = cos_w[6];
      pcoef_c[PT71S] = coef.kt1; ptrig_c[PT71S] = sin_w[6];
      pcoef_c[PL712C] = coef.klc; ptrig_c[PL712C] = cos_w[8];
      pcoef_c[PL712S] = coef.klc; ptrig_c[PL712S] = sin_w[8];
      pcoef_c[PT73C] = coef.kt1; ptrig_c[PT73C] = cos_w[7];
      pcoef_c[PT73S] = coef.kt1; ptrig_c[PT73S] = sin_w[7];
      pcoef_c[PL734C] = coef.klc; ptrig_c[PL734C] = cos_w[9];
      pcoef_c[PL734S] = coef.klc; ptrig_c[PL734S] = sin_w[9];
      pcoef_c[PPL12] = coef.kpl; ptrig_c[PPL12] = cos_w[4];
      pcoef_c[PPL34] = coef.kpl; ptrig_c[PPL34] = cos_w[5];
      pcoef_c[PPT1] = coef.kpt;  ptrig_c[PPT1] = cos_w[0];
      pcoef_c[PPT3] = coef.kpt;  ptrig_c[PPT3] = cos_w[2];
      pcoef_c[PP7C] = coef.kp7;  ptrig_c[PP7C] = cos_w[10];
      pcoef_c[PP7S] = coef.kp7;  ptrig_c[PP7S] = sin_w[10];
   end

   // multiply, then round to q.16 away from zero
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NP; i++) begin
            psign_ff[i] <= ptrig_c[i][31];
            mag_ff[i] <= {31'd0, pcoef_c[i]} *
                         {33'd0, (ptrig_c[i][31] ? 31'(-ptrig_c[i]) : 31'(ptrig_c[i]))};
            p_ff[i] <= psign_ff[i] ? -SW'((mag_ff[i] + (64'd1 << 29)) >> 30)
                                   :  SW'((mag_ff[i] + (64'd1 << 29)) >> 30);
         end
      end
   end

   assign ka_s = $signed(SW'(coef.ka));
   assign kc_s = $signed(SW'(coef.kc));
   assign km_s = $signed(SW'(coef.km));
   assign kd_s = $signed(SW'(coef.kd));

   // first adder level
   always_comb begin
      ha_c[E00] = ka_s;                    hb_c[E00] = p_ff[PB2] <<< 1;
      ha_c[E01] = kc_s;                    hb_c[E01] = p_ff[PB2];
      ha_c[E04] = p_ff[PT71C];             hb_c[E04] = p_ff[PL712C];
      ha_c[E05] = p_ff[PT71S];             hb_c[E05] = p_ff[PL712S];
      ha_c[E06] = ka_s + p_ff[PPL12];      hb_c[E06] = p_ff[PPT1] + (p_ff[PB2] <<< 1);
      ha_c[E11] = kc_s;                    hb_c[E11] = '0;
      ha_c[E14] = p_ff[PL712C];            hb_c[E14] = '0;
      ha_c[E15] = p_ff[PL712S];            hb_c[E15] = '0;
      ha_c[E16] = kc_s + p_ff[PPL12];      hb_c[E16] = p_ff[PB2];
      ha_c[E22] = ka_s;                    hb_c[E22] = p_ff[PB4] <<< 1;
      ha_c[E23] = kc_s;                    hb_c[E23] = p_ff[PB4];
      ha_c[E24] = p_ff[PT73C];             hb_c[E24] = p_ff[PL734C];
      ha_c[E25] = p_ff[PT73S];             hb_c[E25] = p_ff[PL734S];
      ha_c[E26] = ka_s + p_ff[PPL34];      hb_c[E26] = p_ff[PPT3] + (p_ff[PB4] <<< 1);
      ha_c[E33] = kc_s;                    hb_c[E33] = '0;
      ha_c[E34] = p_ff[PL734C];            hb_c[E34] = '0;
      ha_c[E35] = p_ff[PL734S];            hb_c[E35] = '0;
      ha_c[E36] = kc_s + p_ff[PPL34];      hb_c[E36] = p_ff[PB4];
      ha_c[E44] = km_s;                    hb_c[E44] = '0;
      ha_c[E46] = p_ff[PL712C] + p_ff[PL734C] + p_ff[PT71C];
      hb_c[E46] = p_ff[PT73C] + (p_ff[PP7C] <<< 1);
      ha_c[E55] = km_s;                    hb_c[E55] = '0;
      ha_c[E56] = p_ff[PL712S] + p_ff[PL734S] + p_ff[PT71S];
      hb_c[E56] = p_ff[PT73S] + (p_ff[PP7S] <<< 1);
      ha_c[E66] = kd_s + ((p_ff[PPL12] + p_ff[PPL34]) <<< 1);
      hb_c[E66] = (p_ff[PPT1] + p_ff[PPT3] + p_ff[PB2] + p_ff[PB4]) <<< 1;
   end

   // second adder level
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int e = 0; e < NE; e++) begin
            ha_ff[e] <= ha_c[e];
            hb_ff[e] <= hb_c[e];
            e_ff[e]  <= ha_ff[e] + hb_ff[e];
         end
      end
   end

   // rescale to the output format and saturate
   always_comb begin
      for (int e = 0; e < NE; e++) begin
         sh_c[e] = ((e_ff[e] <<< UP) + RND) >>> DN;
         if (sh_c[e] > OUT_MAX)      eo_c[e] = 32'(OUT_MAX);
         else if (sh_c[e] < OUT_MIN) eo_c[e] = 32'(OUT_MIN);
         else                        eo_c[e] = 32'(sh_c[e]);
      end
   end

   // expand the symmetric matrix
   always_comb begin
      for (int r = 0; r < bmm_pkg::ROWS; r++)
         for (int c = 0; c < bmm_pkg::ROWS; c++) full_c[r][c] = '0;
      full_c[0][0] = eo_c[E00];
      full_c[0][1] = eo_c[E01]; full_c[1][0] = eo_c[E01];
      full_c[0][4] = eo_c[E04]; full_c[4][0] = eo_c[E04];
      full_c[0][5] = eo_c[E05]; full_c[5][0] = eo_c[E05];
      full_c[0][6] = eo_c[E06]; full_c[6][0] = eo_c[E06];
      full_c[1][1] = eo_c[E11];
      full_c[1][4] = eo_c[E14]; full_c[4][1] = eo_c[E14];
      full_c[1][5] = eo_c[E15]; full_c[5][1] = eo_c[E15];
      full_c[1][6] = eo_c[E16]; full_c[6][1] = eo_c[E16];
      full_c[2][2] = eo_c[E22];
      full_c[2][3] = eo_c[E23]; full_c[3][2] = eo_c[E23];
      full_c[2][4] = eo_c[E24]; full_c[4][2] = eo_c[E24];
      full_c[2][5] = eo_c[E25]; full_c[5][2] = eo_c[E25];
      full_c[2][6] = eo_c[E26]; full_c[6][2] = eo_c[E26];
      full_c[3][3] = eo_c[E33];
      full_c[3][4] = eo_c[E34]; full_c[4][3] = eo_c[E34];
      full_c[3][5] = eo_c[E35]; full_c[5][3] = eo_c[E35];
      full_c[3][6] = eo_c[E36]; full_c[6][3] = eo_c[E36];
      full_c[4][4] = eo_c[E44];
      full_c[4][6] = eo_c[E46]; full_c[6][4] = eo_c[E46];
      full_c[5][5] = eo_c[E55];
      full_c[5][6] = eo_c[E56]; full_c[6][5] = eo_c[E56];
      full_c[6][6] = eo_c[E66];
   end

   // row serializer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         row_ff  <= '0;
      end else if (drain) begin
         busy_ff <= 1'b0;
         row_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         row_ff <= row_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) mat_ff <= full_c;
   end

   assign rsp_valid              = busy_ff;
   assign rsp_payload.row_number = row_ff;
   assign rsp_payload.elem_col0  = mat_ff[row_ff][0];
   assign rsp_payload.elem_col1  = mat_ff[row_ff][1];
   assign rsp_payload.elem_col2  = mat_ff[row_ff][2];
   assign rsp_payload.elem_col3  = mat_ff[row_ff][3];
   assign rsp_payload.elem_col4  = mat_ff[row_ff][4];
   assign rsp_payload.elem_col5  = mat_ff[row_ff][5];
   assign rsp_payload.elem_col6  = mat_ff[row_ff][6];
   assign rsp_payload.last_row   = (row_ff == bmm_pkg::LAST_ROW);

endmodule

@@ rtl/core/bmm_checker.sv @@
module bmm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input bmm_pkg::req_type  req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bmm_pkg::rsp_type  rsp_payload,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [2:0]        csr_index,
   input logic [47:0]       csr_data
);

   // a stalled row holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("row changed while stalled");

   // rows of one matrix follow in order with no gap
   a_row_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_row |=>
         rsp_valid && (rsp_payload.row_number == $past(rsp_payload.row_number) + 3'd1))
      else $error("row sequence broken");

   // last flag marks row six only
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_row == (rsp_payload.row_number == bmm_pkg::LAST_ROW)))
      else $error("last row flag mismatch");

   // a matrix that follows an idle cycle starts at row zero
   a_first_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_payload.row_number == 3'd0)
      else $error("matrix does not start at row zero");

   // nothing shown right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind biped_mass_matrix bmm_checker u_bmm_checker (.*);

@@ sim/biped_mass_matrix_tb.sv @@
module biped_mass_matrix_tb;
   import bmm_pkg::*;

   // scoreboard: own copy of the link registers and the predicted rows
   class mass_matrix_board;
      logic [23:0] len_thigh, len_leg, off_pelvis, m_thigh, i_thigh, m_leg, i_leg;
      logic [47:0] torso_mi;
      rsp_type     expected_rows[$];
      int          mismatches;

      function new();
         len_thigh = 24'd12452; len_leg = 24'd15401; off_pelvis = 24'd13763;
         m_thigh = 24'd45875; i_thigh = 24'd293; m_leg = 24'd45875; i_leg = 24'd293;
         torso_mi = 48'd13743895386548;
         mismatches = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [47:0] data);
         case (idx)
            CSR_THIGH_LENGTH:       len_thigh  = data[23:0];
            CSR_LEG_LENGTH:         len_leg    = data[23:0];
            CSR_PELVIS_HIP_OFFSET:  off_pelvis = data[23:0];
            CSR_THIGH_MASS:         m_thigh    = data[23:0];
            CSR_THIGH_INERTIA:      i_thigh    = data[23:0];
            CSR_LEG_MASS:           m_leg      = data[23:0];
            CSR_LEG_INERTIA:        i_leg      = data[23:0];
            CSR_TORSO_MASS_INERTIA: torso_mi   = data;
            default: ;
         endcase
      endfunction

      function longint unsigned clip33(longint unsigned v);
         return (v > 64'h1_FFFF_FFFF) ? 64'h1_FFFF_FFFF : v;
      endfunction

      // unsigned product rounded half up
      function longint unsigned umul(longint unsigned a, longint unsigned b, int sh);
         longint unsigned p;
         p = clip33(a) * (b & 64'h3FF_FFFF);
         return clip33((p + (64'd1 << (sh - 1))) >> sh);
      endfunction

      function longint unsigned usum(longint unsigned a, longint unsigned b);
         return clip33(clip33(a) + clip33(b));
      endfunction

      // coefficient times trig value, rounded away from zero on ties
      function longint cmul(longint unsigned coef, longint t);
         longint unsigned mag;
         longint r;
         mag = clip33(coef) * longint'(t < 0 ? -t : t);
         r = longint'((mag + (64'd1 << 29)) >> 30);
         return (t < 0) ? -r : r;
      endfunction

      function longint atan_step(int i);
         case (i)
            0: return 13176795;
            1: return 7778716;
            2: return 4110060;
            3: return 2086331;
            4: return 1047214;
            5: return 524117;
            6: return 262123;
            7: return 131069;
            default: return longint'(65536) >>> (i - 8);
         endcase
      endfunction

      // range reduction then 24 cordic rotations
      function void rotate(longint a, output longint c, output longint s);
         longint x, y, z, nx;
         bit flip;
         x = 652032874; y = 0; z = a % 105414358; flip = 0;
         if (z > 52707179) z -= 105414358;
         else if (z < -52707179) z += 105414358;
         if (z > 26353589) begin
            z -= 52707179; flip = 1;
         end else if (z < -26353589) begin
            z += 52707179; flip = 1;
         end
         for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
            end else begin
               nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
            end
            x = nx;
         end
         if (flip) begin
            x = -x; y = -y;
         end
         if (x > 1073741824) x = 1073741824;
         if (x < -1073741824) x = -1073741824;
         if (y > 1073741824) y = 1073741824;
         if (y < -1073741824) y = -1073741824;
         c = x; s = y;
      endfunction

      function logic signed [31:0] sat32(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      // mass matrix of one pose, pushed as seven rows
      function void note_pose(req_type p);
         longint unsigned lt, ll, pp, mt, it, ml, il, mp, ip;
         longint unsigned klc, kb, ka, kc, kt1, kpl, kpt, km, kp7, kd;
         longint q1, q2, q3, q4, q7;
         longint c1, s1, c2, s2, c3, s3, c4, s4, c12, s12, c34, s34;
         longint c71, s71, c73, s73, c712, s712, c734, s734, c7, s7;
         longint m[7][7];
         logic signed [31:0] e[7];
         rsp_type row;
         lt = len_thigh; ll = len_leg; pp = off_pelvis; mt = m_thigh; it = i_thigh;
         ml = m_leg; il = i_leg; mp = torso_mi[47:24]; ip = torso_mi[23:0];
         q1 = longint'(p.right_hip_angle) * 2048;
         q2 = longint'(p.right_knee_angle) * 2048;
         q3 = longint'(p.left_hip_angle) * 2048;
         q4 = longint'(p.left_knee_angle) * 2048;
         q7 = longint'(p.torso_pitch) * 2048;
         rotate(q1, c1, s1); rotate(q2, c2, s2); rotate(q3, c3, s3); rotate(q4, c4, s4);
         rotate(q1 + q2, c12, s12); rotate(q3 + q4, c34, s34);
         rotate(q7 + q1, c71, s71); rotate(q7 + q3, c73, s73);
         rotate(q7 + q1 + q2, c712, s712); rotate(q7 + q3 + q4, c734, s734);
         rotate(q7, c7, s7);
         klc = umul(ml, ll, 17);
         kb  = umul(klc, lt, 16);
         kc  = usum(il, umul(klc, ll, 17));
         ka  = usum(usum(kc, it), usum(umul(umul(lt, lt, 16), ml, 16),
                                        umul(umul(mt, lt, 17), lt, 17)));
         kt1 = usum(umul(ml, lt, 16), umul(mt, lt, 17));
         kpl = umul(klc, pp, 16);
         kpt = umul(kt1, pp, 16);
         km  = usum(usum(2 * ml, mp), 2 * mt);
         kp7 = umul(ml + mt, pp, 16);
         kd  = usum(usum(2 * clip33(ka), ip), 2 * umul(umul(pp, pp, 16), ml + mt, 16));
         foreach (m[r, j]) m[r][j] = 0;
         m[0][0] = longint'(ka) + 2 * cmul(kb, c2);
         m[0][1] = longint'(kc) + cmul(kb, c2);
         m[0][4] = cmul(kt1, c71) + cmul(klc, c712);
         m[0][5] = cmul(kt1, s71) + cmul(klc, s712);
         m[0][6] = longint'(ka) + cmul(kpl, c12) + cmul(kpt, c1) + 2 * cmul(kb, c2);
         m[1][1] = longint'(kc);
         m[1][4] = cmul(klc, c712);
         m[1][5] = cmul(klc, s712);
         m[1][6] = longint'(kc) + cmul(kpl, c12) + cmul(kb, c2);
         m[2][2] = longint'(ka) + 2 * cmul(kb, c4);
         m[2][3] = longint'(kc) + cmul(kb, c4);
         m[2][4] = cmul(kt1, c73) + cmul(klc, c734);
         m[2][5] = cmul(kt1, s73) + cmul(klc, s734);
         m[2][6] = longint'(ka) + cmul(kpl, c34) + cmul(kpt, c3) + 2 * cmul(kb, c4);
         m[3][3] = longint'(kc);
         m[3][4] = cmul(klc, c734);
         m[3][5] = cmul(klc, s734);
         m[3][6] = longint'(kc) + cmul(kpl, c34) + cmul(kb, c4);
         m[4][4] = longint'(km);
         m[4][6] = cmul(klc, c712) + cmul(klc, c734) + cmul(kt1, c71) + cmul(kt1, c73)
                   + 2 * cmul(kp7, c7);
         m[5][5] = longint'(km);
         m[5][6] = cmul(klc, s712) + cmul(klc, s734) + cmul(kt1, s71) + cmul(kt1, s73)
                   + 2 * cmul(kp7, s7);
         m[6][6] = longint'(kd) + 2 * (cmul(kpl, c12) + cmul(kpl, c34) + cmul(kpt, c1)
                   + cmul(kpt, c3) + cmul(kb, c2) + cmul(kb, c4));
         for (int r = 0; r < 7; r++)
            for (int j = 0; j < r; j++)
               m[r][j] = m[j][r];
         for (int r = 0; r < 7; r++) begin
            for (int j = 0; j < 7; j++) e[j] = sat32(m[r][j]);
            row.row_number = 3'(r);
            row.elem_col0 = e[0]; row.elem_col1 = e[1]; row.elem_col2 = e[2];
            row.elem_col3 = e[3]; row.elem_col4 = e[4]; row.elem_col5 = e[5];
            row.elem_col6 = e[6];
            row.last_row = (r == 6);
            expected_rows.push_back(row);
         end
      endfunction

      function void check_row(rsp_type got);
         rsp_type want;
         if (expected_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected row %h", got);
            return;
         end
         want = expected_rows.pop_front();
         if (got.row_number !== want.row_number || got.elem_col0 !== want.elem_col0 ||
             got.elem_col1 !== want.elem_col1 || got.elem_col2 !== want.elem_col2 ||
             got.elem_col3 !== want.elem_col3 || got.elem_col4 !== want.elem_col4 ||
             got.elem_col5 !== want.elem_col5 || got.elem_col6 !== want.elem_col6 ||
             got.last_row !== want.last_row) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("row mismatch expected row %0d: %h %h %h %h %h %h %h last %b",
                        want.row_number, want.elem_col0, want.elem_col1, want.elem_col2,
                        want.elem_col3, want.elem_col4, want.elem_col5, want.elem_col6,
                        want.last_row);
               $display("             actual   row %0d: %h %h %h %h %h %h %h last %b",
                        got.row_number, got.elem_col0, got.elem_col1, got.elem_col2,
                        got.elem_col3, got.elem_col4, got.elem_col5, got.elem_col6,
                        got.last_row);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_payload;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_data = '0;

   mass_matrix_board board;
   bit          calm = 0;
   int          quiet_cycles = 0;

   biped_mass_matrix u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
   end

   // row checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_row(rsp_payload);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= 3000) begin
            $display("biped_mass_matrix regression: fail");
            $finish;
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [47:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one register set; upper bits of the narrow registers are random filler
   task automatic write_all(logic [23:0] v[7], logic [47:0] torso);
      for (int i = 0; i < 7; i++)
         write_reg(csr_index_type'(i), {24'($urandom), v[i]});
      write_reg(CSR_TORSO_MASS_INERTIA, torso);
   endtask

   task automatic send_pose(req_type p);
      @(negedge clock);
      if (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      board.note_pose(p);
   endtask

   function automatic logic signed [15:0] rand_angle();
      if ($urandom_range(9) < 8) return 16'($urandom_range(51472) - 25736);
      return 16'($urandom);
   endfunction

   task automatic send_random(int n);
      req_type p;
      for (int k = 0; k < n; k++) begin
         p.right_hip_angle  = rand_angle();
         p.right_knee_angle = rand_angle();
         p.left_hip_angle   = rand_angle();
         p.left_knee_angle  = rand_angle();
         p.torso_pitch      = rand_angle();
         send_pose(p);
      end
   endtask

   // let the pipeline drain before touching registers
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_rows.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      logic [23:0] regs[7];
      logic signed [15:0] corner[10];
      req_type p;
      board = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults, directed poses, then random poses
      regs = '{24'd12452, 24'd15401, 24'd13763, 24'd45875, 24'd293, 24'd45875, 24'd293};
      write_all(regs, 48'd13743895386548);
      corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sh7FFF, 16'sh8000,
                 16'sd12868, -16'sd12868, 16'sd25735, 16'sd1, -16'sd1};
      foreach (corner[i]) begin
         p = {5{corner[i]}};
         send_pose(p);
      end
      for (int i = 0; i < 5; i++) begin
         p = '0;
         p[16*i +: 16] = 16'sd25736;
         send_pose(p);
         p[16*i +: 16] = 16'sh8000;
         send_pose(p);
      end
      send_random(30);
      drain();

      // everything at full scale, saturating many coefficients and outputs
      regs = '{7{24'hFF_FFFF}};
      write_all(regs, 48'hFFFF_FFFF_FFFF);
      send_random(30);
      drain();

      // everything zero
      regs = '{7{24'd0}};
      write_all(regs, 48'd0);
      send_random(20);
      drain();

      // random full-range registers
      foreach (regs[i]) regs[i] = 24'($urandom);
      write_all(regs, {16'($urandom), 32'($urandom)});
      send_random(40);
      drain();

      // plausible link values, one long stretch with no idling, then one with random stalls
      foreach (regs[i]) regs[i] = 24'($urandom_range(1 << 18));
      write_all(regs, {24'($urandom_range(1 << 20)), 24'($urandom_range(1 << 16))});
      calm = 1;
      send_random(60);
      drain();
      calm = 0;
      send_random(50);
      drain();

      if (board.mismatches == 0 && board.expected_rows.size() == 0)
         $display("biped_mass_matrix regression: pass");
      else
         $display("biped_mass_matrix regression: fail");
      $finish;
   end
endmodule
